>>> rtl/sha1md_pkg.sv
// Shared types, constants and round functions for the SHA-1 digest block.
// Used by sha1md_front, sha1md_back and sha1_message_digest.
`default_nettype none

package sha1md_pkg;

  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned RoundCount  = 80;
  localparam int unsigned DigestWords = 5;
  localparam int unsigned OutDataW    = 40;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] FillLast = 6'd63;

  localparam logic [31:0] InitH0 = 32'h67452301;
  localparam logic [31:0] InitH1 = 32'hEFCDAB89;
  localparam logic [31:0] InitH2 = 32'h98BADCFE;
  localparam logic [31:0] InitH3 = 32'h10325476;
  localparam logic [31:0] InitH4 = 32'hC3D2E1F0;

  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = InitH0;
      3'd1:    w = InitH1;
      3'd2:    w = InitH2;
      3'd3:    w = InitH3;
      default: w = InitH4;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = RoundK0;
    end else if (rnd < 7'd40) begin
      k = RoundK1;
    end else if (rnd < 7'd60) begin
      k = RoundK2;
    end else begin
      k = RoundK3;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd >= 7'd40 && rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sha1md_front.sv
// Input side: accepts stream transfers, drops items that carry neither a byte
// nor an end mark, and queues the rest. Depends on sha1md_pkg.
`default_nettype none

module sha1md_front #(
  parameter int unsigned Depth = sha1md_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         s_axis_tdata_i,  // data_byte
  input  wire logic               s_axis_tuser_i,  // byte_present
  input  wire logic               s_axis_tlast_i,  // end_of_message
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  output sha1md_pkg::item_t       item_o,
  output logic                    item_valid_o,
  input  wire logic               item_ready_i
);
  import sha1md_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw = $clog2(Depth + 1);

  item_t         mem_q [Depth];
  logic [Aw-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic          push, pop;
  item_t         item_in;

  assign item_in.data_byte      = s_axis_tdata_i;
  assign item_in.byte_present   = s_axis_tuser_i;
  assign item_in.end_of_message = s_axis_tlast_i;

  assign s_axis_tready_o = (cnt_q != Cw'(Depth));
  assign push = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i || s_axis_tlast_i);
  assign item_valid_o = (cnt_q != '0);
  assign pop = item_valid_o && item_ready_i;
  assign item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Aw'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Aw'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sha1md_back.sv
// Processing side: gathers bytes into the block, pads, runs the 80-round
// compression one round per cycle and emits the digest through an output
// register. Depends on sha1md_pkg.
`default_nettype none

module sha1md_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sha1md_pkg::item_t              item_i,
  input  wire logic                           item_valid_i,
  output logic                                item_ready_o,
  output logic [sha1md_pkg::OutDataW-1:0]     m_axis_tdata_o,  // digest_word, word_index
  output logic                                m_axis_tlast_o,  // last_word
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i
);
  import sha1md_pkg::*;

  localparam logic [2:0] S_IN    = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_COMP  = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]          state_q, state_d, ret_q, ret_d;
  logic [5:0]          fill_q, fill_d;
  logic [63:0]         len_q, len_d;
  logic [511:0]        blk_q, blk_d;
  logic [31:0]         h_q [DigestWords];
  logic [31:0]         h_d [DigestWords];
  logic [31:0]         a_q, b_q, c_q, d_q, e_q;
  logic [31:0]         a_d, b_d, c_d, d_d, e_d;
  logic [6:0]          rnd_q, rnd_d;
  logic [2:0]          oidx_q, oidx_d;
  logic                m_valid_q, m_valid_d, m_last_q, m_last_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic        app_en;
  logic [7:0]  app_byte;
  logic        comp_start;
  logic [2:0]  comp_ret;
  logic        out_free;
  logic [31:0] w_cur, w_new, t_sum;
  logic [63:0] len_sh;

  function automatic logic [31:0] w_new_pre(input logic [511:0] blk);
    logic [31:0] x;
    x = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
    return {x[30:0], x[31]};
  endfunction

  assign w_cur  = blk_q[511:480];
  assign w_new  = {w_new_pre(blk_q)};
  assign t_sum  = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q + w_cur
                  + round_k(rnd_q);
  assign len_sh = len_q << {fill_q[2:0], 3'b000};
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign item_ready_o = (state_q == S_IN);

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    fill_d     = fill_q;
    len_d      = len_q;
    blk_d      = blk_q;
    h_d        = h_q;
    a_d        = a_q;
    b_d        = b_q;
    c_d        = c_q;
    d_d        = d_q;
    e_d        = e_q;
    rnd_d      = rnd_q;
    oidx_d     = oidx_q;
    m_valid_d  = m_valid_q;
    m_last_d   = m_last_q;
    m_data_d   = m_data_q;
    app_en     = 1'b0;
    app_byte   = '0;
    comp_start = 1'b0;
    comp_ret   = S_IN;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IN: begin
        if (item_valid_i) begin
          if (item_i.byte_present) begin
            app_en   = 1'b1;
            app_byte = item_i.data_byte;
            len_d    = len_q + 64'd8;
          end
          if (item_i.byte_present && fill_q == FillLast) begin
            comp_start = 1'b1;
            comp_ret   = item_i.end_of_message ? S_PAD80 : S_IN;
          end else if (item_i.end_of_message) begin
            state_d = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        app_en   = 1'b1;
        app_byte = PadByte;
        if (fill_q == FillLast) begin
          comp_start = 1'b1;
          comp_ret   = S_ZERO;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        if (fill_q == LenStart) begin
          state_d = S_LEN;
        end else begin
          app_en = 1'b1;
          if (fill_q == FillLast) begin
            comp_start = 1'b1;
            comp_ret   = S_ZERO;
          end
        end
      end
      S_LEN: begin
        app_en   = 1'b1;
        app_byte = len_sh[63:56];
        if (fill_q == FillLast) begin
          comp_start = 1'b1;
          comp_ret   = S_OUT;
        end
      end
      S_COMP: begin
        blk_d = {blk_q[479:0], w_new};
        e_d   = d_q;
        d_d   = c_q;
        c_d   = {b_q[1:0], b_q[31:2]};
        b_d   = a_q;
        a_d   = t_sum;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == 7'(RoundCount - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        h_d[0]  = h_q[0] + a_q;
        h_d[1]  = h_q[1] + b_q;
        h_d[2]  = h_q[2] + c_q;
        h_d[3]  = h_q[3] + d_q;
        h_d[4]  = h_q[4] + e_q;
        state_d = ret_q;
      end
      S_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'b0, oidx_q, h_q[oidx_q]};
          m_last_d  = (oidx_q == 3'(DigestWords - 1));
          if (oidx_q == 3'(DigestWords - 1)) begin
            oidx_d = '0;
            len_d  = '0;
            fill_d = '0;
            for (int i = 0; i < DigestWords; i++) begin
              h_d[i] = init_word(3'(i));
            end
            state_d = S_IN;
          end else begin
            oidx_d = oidx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IN;
      end
    endcase

    if (app_en) begin
      blk_d  = {blk_q[503:0], app_byte};
      fill_d = fill_q + 1'b1;
    end
    if (comp_start) begin
      state_d = S_COMP;
      ret_d   = comp_ret;
      rnd_d   = '0;
      fill_d  = '0;
      a_d     = h_q[0];
      b_d     = h_q[1];
      c_d     = h_q[2];
      d_d     = h_q[3];
      e_d     = h_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    d_q      <= d_d;
    e_q      <= e_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IN;
      ret_q     <= S_IN;
      fill_q    <= '0;
      len_q     <= '0;
      rnd_q     <= '0;
      oidx_q    <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < DigestWords; i++) begin
        h_q[i] <= init_word(3'(i));
      end
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      fill_q    <= fill_d;
      len_q     <= len_d;
      rnd_q     <= rnd_d;
      oidx_q    <= oidx_d;
      m_valid_q <= m_valid_d;
      h_q       <= h_d;
    end
  end

  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tvalid_o = m_valid_q;

endmodule

`default_nettype wire

>>> rtl/sha1_message_digest.sv
// SHA-1 message digest over a byte stream, top level.
// Instantiates sha1md_front and sha1md_back; depends on sha1md_pkg.
//
// Slave stream: one message byte per transfer in tdata[7:0]; tuser marks that
// the byte belongs to the message, tlast closes the message. A transfer with
// tlast and no byte closes the message as it stands (empty message allowed).
// Transfers with neither are dropped. A small queue in the front keeps the
// slave side taking transfers while the back end compresses.
// Master stream: five transfers per message, digest word in tdata[31:0],
// word index in tdata[34:32], tlast on the fifth word.
// Throughput: one byte per cycle into the block while the back end is in its
// input phase and the queue holds items; each 64-byte block is then compressed
// (80 rounds plus the chaining add), and the single round unit sets the rate.
// Closing a message pads one byte per cycle, with an idle step before the length,
// and adds a second compression when the length does not fit the last block; then
// the final compression runs, and the five words follow one per cycle while the
// receiver takes them.
// A master-side stall holds the output register; the back end waits in its
// output phase and the queue fills before the slave side stalls.
// Reset loads the initial chaining values and clears the length and queue.
`default_nettype none

module sha1_message_digest #(
  parameter int unsigned QUEUE_DEPTH = sha1md_pkg::QueueDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [7:0]                     s_axis_tdata_i,  // data_byte
  input  wire logic                           s_axis_tuser_i,  // byte_present
  input  wire logic                           s_axis_tlast_i,  // end_of_message
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  output logic [sha1md_pkg::OutDataW-1:0]     m_axis_tdata_o,  // digest_word, word_index
  output logic                                m_axis_tlast_o,  // last_word
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i
);
  import sha1md_pkg::*;

  item_t item;
  logic  item_valid, item_ready;

  sha1md_front #(
    .Depth(QUEUE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .item_o         (item),
    .item_valid_o   (item_valid),
    .item_ready_i   (item_ready)
  );

  sha1md_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

endmodule

`default_nettype wire

>>> sim/sha1_message_digest_check.sv
// Checker for sha1_message_digest: watches both stream channels, predicts
// the SHA-1 digest words and compares each master transfer in order.
// Needs sha1md_pkg for the output width; reports mismatches and a fail count.
module sha1_message_digest_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [7:0]                      s_tdata_i,
  input  logic                            s_tuser_i,
  input  logic                            s_tlast_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [sha1md_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                            m_tlast_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  output int unsigned                     fail_cnt_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] ShaK0 = 32'h5A827999;
  localparam logic [31:0] ShaK1 = 32'h6ED9EBA1;
  localparam logic [31:0] ShaK2 = 32'h8F1BBCDC;
  localparam logic [31:0] ShaK3 = 32'hCA62C1D6;
  localparam logic [31:0] ShaIv [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                        32'h10325476, 32'hC3D2E1F0};

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0]  chain_h [5];
  logic [7:0]   blk_bytes [64];
  int unsigned  blk_fill;
  logic [63:0]  msg_bits;
  digest_word_t digest_q [$];
  int unsigned  fails;

  function automatic void restart_message();
    for (int i = 0; i < 5; i++) chain_h[i] = ShaIv[i];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int unsigned r;
    for (r = 0; r < 16; r++) begin
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        x = w[r];
      end else begin
        x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
        x = {x[30:0], x[31]};
        w[r % 16] = x;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = ShaK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = ShaK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = ShaK2;
      end else begin
        f = b ^ c ^ d;
        k = ShaK3;
      end
      t = {a[26:0], a[31:27]} + f + e + x + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // pad, append the length, run the final compression(s), queue the digest
  function automatic void close_message();
    int unsigned pos;
    digest_word_t dw;
    pos = blk_fill;
    blk_bytes[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        blk_bytes[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      blk_bytes[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) blk_bytes[56 + i] = msg_bits[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      dw.word = chain_h[i];
      dw.idx  = 3'(i);
      dw.last = (i == 4);
      digest_q = {digest_q, dw};
    end
    restart_message();
  endfunction

  function automatic void absorb_item(logic [7:0] data, logic present, logic close);
    if (present) begin
      blk_bytes[blk_fill] = data;
      blk_fill++;
      msg_bits += 64'd8;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (close) close_message();
  endfunction

  function automatic void check_word();
    digest_word_t want;
    if (digest_q.size() == 0) begin
      fails++;
      $display("%0t ns: unexpected digest word: expected none, got %h idx %0d last %0b",
               $time, m_tdata_i[31:0], m_tdata_i[34:32], m_tlast_i);
    end else begin
      want = digest_q.pop_front();
      if (m_tdata_i[31:0] !== want.word) begin
        fails++;
        $display("%0t ns: digest word: expected %h, got %h",
                 $time, want.word, m_tdata_i[31:0]);
      end
      if (m_tdata_i[34:32] !== want.idx) begin
        fails++;
        $display("%0t ns: word index: expected %0d, got %0d",
                 $time, want.idx, m_tdata_i[34:32]);
      end
      if (m_tlast_i !== want.last) begin
        fails++;
        $display("%0t ns: last word flag: expected %0b, got %0b",
                 $time, want.last, m_tlast_i);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      digest_q.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_word();
      if (s_tvalid_i && s_tready_i) absorb_item(s_tdata_i, s_tuser_i, s_tlast_i);
      fail_cnt_o <= fails;
      pending_o  <= digest_q.size();
    end
  end

endmodule

>>> sim/sha1_message_digest_test.sv
// Testbench top for sha1_message_digest: clock, reset, byte stream stimulus
// with random pacing, digest receiver with stalls, and the final verdict.
// Depends on sha1md_pkg, the RTL and sha1_message_digest_check.
module sha1_message_digest_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int unsigned {PaceBurst, PaceRandom, PaceSparse} pace_e;

  localparam int unsigned ItemTarget = 340;
  localparam int unsigned HoldWord   = 22;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CornerLen [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic [7:0]                      s_tdata;
  logic                            s_tuser;
  logic                            s_tlast;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [sha1md_pkg::OutDataW-1:0] m_tdata;
  logic                            m_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  int unsigned                     fail_cnt;
  int unsigned                     pending;

  int unsigned items_sent;
  int unsigned put_calls;
  pace_e       tx_pace;

  sha1_message_digest u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready)
  );

  sha1_message_digest_check u_check (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_tdata_i (s_tdata),
    .s_tuser_i (s_tuser),
    .s_tlast_i (s_tlast),
    .s_tvalid_i(s_tvalid),
    .s_tready_i(s_tready),
    .m_tdata_i (m_tdata),
    .m_tlast_i (m_tlast),
    .m_tvalid_i(m_tvalid),
    .m_tready_i(m_tready),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned draw_gap(input pace_e pace);
    int unsigned gap;
    case (pace)
      PaceBurst:  gap = 0;
      PaceRandom: gap = $urandom_range(0, 18);
      default:    gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    endcase
    return gap;
  endfunction

  task automatic put_item(input logic [7:0] data, input logic present, input logic close);
    int unsigned gap;
    if (put_calls % 24 == 0) tx_pace = pace_e'($urandom_range(0, 2));
    put_calls++;
    gap = draw_gap(tx_pace);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= data;
    s_tuser  <= present;
    s_tlast  <= close;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (present || close) items_sent++;
  endtask

  // random content; closes on the last byte or with a separate empty transfer
  task automatic send_message(input int unsigned len, input bit close_on_byte);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) put_item(8'($urandom), 1'b0, 1'b0);
      put_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte || len == 0) put_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int unsigned pick_len();
    int unsigned len;
    if ($urandom_range(0, 3) == 0) begin
      len = CornerLen[$urandom_range(0, 9)];
    end else begin
      len = $urandom_range(0, 40);
    end
    return len;
  endfunction

  initial begin
    rst_n      <= 1'b0;
    s_tvalid   <= 1'b0;
    s_tdata    <= 8'h00;
    s_tuser    <= 1'b0;
    s_tlast    <= 1'b0;
    items_sent = 0;
    put_calls  = 0;
    tx_pace    = PaceBurst;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty message
    put_item(8'h5A, 1'b0, 1'b1);
    // "abc", closed on the last byte
    put_item(8'h61, 1'b1, 1'b0);
    put_item(8'h62, 1'b1, 1'b0);
    put_item(8'h63, 1'b1, 1'b1);
    // transfer that carries neither byte nor close
    put_item(8'hFF, 1'b0, 1'b0);
    // extremes: one message closed by an empty transfer, then two one-byte messages
    put_item(8'h00, 1'b1, 1'b0);
    put_item(8'hFF, 1'b1, 1'b0);
    put_item(8'hA5, 1'b0, 1'b1);
    put_item(8'hFF, 1'b1, 1'b1);
    put_item(8'h00, 1'b1, 1'b1);

    // length needs a second final block, then a block-full message
    send_message(56, $urandom_range(0, 1));
    send_message(64, $urandom_range(0, 1));
    while (items_sent < ItemTarget) send_message(pick_len(), $urandom_range(0, 1));
    s_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[sha1_message_digest] OK");
    end else begin
      $display("[sha1_message_digest] ERROR");
    end
    $finish;
  end

  // digest receiver; one long hold-off lets the input queue fill up
  initial begin
    int unsigned gap;
    int unsigned taken;
    pace_e       rx_pace;
    m_tready <= 1'b0;
    taken   = 0;
    rx_pace = PaceBurst;
    @(posedge rst_n);
    forever begin
      if (taken % 24 == 0) rx_pace = pace_e'($urandom_range(0, 2));
      gap = (taken == HoldWord) ? HoldCycles : draw_gap(rx_pace);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    #20ms;
    $display("[sha1_message_digest] ERROR");
    $finish;
  end

endmodule
